/* hw/rtl/depq_pkg.sv */
// types and constants shared by the double-ended priority queue
// no dependencies
package depq_pkg;

  localparam int unsigned DATA_W = 32;

  typedef enum logic [1:0] {
    KIND_INSERT  = 2'd0,
    KIND_DEL_MAX = 2'd1,
    KIND_DEL_MIN = 2'd2,
    KIND_CLEAR   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_EMPTY_DEL = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_POP_FRONT,
    CMD_POP_BACK,
    CMD_CLEAR
  } cmd_t;

  typedef struct packed {
    logic                     valid;
    logic                     gt;
    logic signed [DATA_W-1:0] value;
  } link_t;

  // virtual neighbour below cell zero: occupied, never above the new word
  localparam link_t LINK_LOW = '{valid: 1'b1, gt: 1'b0, value: '0};
  // virtual neighbour above the last cell: empty
  localparam link_t LINK_END = '{valid: 1'b0, gt: 1'b0, value: '0};

endpackage

/* hw/rtl/depq_cell.sv */
// one cell of the sorted register chain: a word and its occupied flag
// depends on depq_pkg
module depq_cell
  import depq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  input  logic signed [DATA_W-1:0] ins_value,
  input  link_t                    lower,
  input  link_t                    upper,
  output link_t                    self
);

  logic                     valid_r, valid_nxt;
  logic signed [DATA_W-1:0] value_r, value_nxt;
  logic                     gt;

  assign gt = valid_r && (value_r > ins_value);

  assign self.valid = valid_r;
  assign self.gt    = gt;
  assign self.value = value_r;

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    case (cmd)
      CMD_INSERT: begin
        valid_nxt = valid_r | lower.valid;
        if (valid_r && !gt) begin
          value_nxt = value_r;
        end else if (lower.gt) begin
          value_nxt = lower.value;
        end else begin
          value_nxt = ins_value;
        end
      end
      CMD_POP_FRONT: begin
        valid_nxt = upper.valid;
        value_nxt = upper.value;
      end
      CMD_POP_BACK: begin
        valid_nxt = valid_r & upper.valid;
      end
      CMD_CLEAR: begin
        valid_nxt = 1'b0;
      end
      default: begin
        valid_nxt = valid_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

/* hw/rtl/depq_chain.sv */
// ascending sorted chain of cells, smallest word in cell zero
// depends on depq_pkg and depq_cell
module depq_chain
  import depq_pkg::*;
#(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  input  logic signed [DATA_W-1:0] ins_value,
  output link_t                    head,
  output logic                     full
);

  link_t links [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    link_t lower, upper;
    if (i == 0) begin : g_low
      assign lower = LINK_LOW;
    end else begin : g_mid_low
      assign lower = links[i-1];
    end
    if (i == DEPTH - 1) begin : g_top
      assign upper = LINK_END;
    end else begin : g_mid_top
      assign upper = links[i+1];
    end
    depq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .ins_value (ins_value),
      .lower     (lower),
      .upper     (upper),
      .self      (links[i])
    );
  end

  assign head = links[0];
  assign full = links[DEPTH-1].valid;

endmodule

/* hw/rtl/double_ended_priority_queue_unit.sv */
// Double-ended priority queue of up to CAPACITY signed 32-bit words,
// duplicates allowed. One operation is taken every clock cycle (busy stays
// low); its result appears on the out_ ports for one cycle, in the cycle after
// the start cycle, and cannot be held off. The words live in two sorted
// register chains of CAPACITY cells, one ascending and one holding the
// inverted words, so both the minimum and the maximum sit in cell zero and
// every operation is a single neighbour-to-neighbour step of all cells.
// depends on depq_pkg and depq_chain
module double_ended_priority_queue_unit
  import depq_pkg::*;
#(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_kind,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_strobe,
  output logic                     out_is_empty,
  output logic signed [DATA_W-1:0] out_max_value,
  output logic signed [DATA_W-1:0] out_min_value,
  output logic [1:0]               out_status
);

  cmd_t    asc_cmd, desc_cmd;
  status_t status_nxt, status_r;
  link_t   asc_head, desc_head;
  logic    asc_full, desc_full;
  logic    empty, full;
  logic    accept;
  logic    strobe_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign empty  = !asc_head.valid;
  assign full   = asc_full;

  always_comb begin
    asc_cmd    = CMD_HOLD;
    desc_cmd   = CMD_HOLD;
    status_nxt = ST_DONE;
    if (accept) begin
      case (kind_t'(in_kind))
        KIND_INSERT: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            asc_cmd  = CMD_INSERT;
            desc_cmd = CMD_INSERT;
          end
        end
        KIND_DEL_MAX: begin
          if (empty) begin
            status_nxt = ST_EMPTY_DEL;
          end else begin
            asc_cmd  = CMD_POP_BACK;
            desc_cmd = CMD_POP_FRONT;
          end
        end
        KIND_DEL_MIN: begin
          if (empty) begin
            status_nxt = ST_EMPTY_DEL;
          end else begin
            asc_cmd  = CMD_POP_FRONT;
            desc_cmd = CMD_POP_BACK;
          end
        end
        KIND_CLEAR: begin
          asc_cmd  = CMD_CLEAR;
          desc_cmd = CMD_CLEAR;
        end
        default: begin
          asc_cmd = CMD_HOLD;
        end
      endcase
    end
  end

  depq_chain #(
    .DEPTH (CAPACITY)
  ) u_asc (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (asc_cmd),
    .ins_value (in_value),
    .head      (asc_head),
    .full      (asc_full)
  );

  // inverted words sort in reverse, so the maximum heads this chain
  depq_chain #(
    .DEPTH (CAPACITY)
  ) u_desc (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (desc_cmd),
    .ins_value (~in_value),
    .head      (desc_head),
    .full      (desc_full)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
      status_r <= ST_DONE;
    end else begin
      strobe_r <= accept;
      status_r <= status_nxt;
    end
  end

  assign out_strobe    = strobe_r;
  assign out_status    = status_r;
  assign out_is_empty  = !asc_head.valid;
  assign out_min_value = asc_head.valid ? asc_head.value : '0;
  assign out_max_value = desc_head.valid ? ~desc_head.value : '0;

`ifndef SYNTHESIS
  a_chains_empty_agree : assert property (@(posedge clk) disable iff (!rst_n)
    asc_head.valid == desc_head.valid)
    else $error("chains disagree on empty");

  a_chains_full_agree : assert property (@(posedge clk) disable iff (!rst_n)
    asc_full == desc_full)
    else $error("chains disagree on full");

  a_max_not_below_min : assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_is_empty) |-> (out_max_value >= out_min_value))
    else $error("maximum below minimum");

  a_clear_empties : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_kind == KIND_CLEAR) |=> (out_strobe && out_is_empty))
    else $error("queue not empty after clear");
`endif

endmodule
